[rtl/utrt_pkg.sv]
// utrt_pkg: transaction types, character constants and the digit-to-text
// mapping for the unsigned-to-radix-text converter
// no dependencies
package utrt_pkg;

  localparam int VALUE_W = 32;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 6;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_ALPHA   = 7'd55;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CHAR_NUL     = 7'd0;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 7'd57;  // '9'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'd90;  // 'Z'
  localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FETCH,
    ST_LOAD,
    ST_TERM
  } state_t;

  // digit value 0..35 to its ascii code
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + d_ext;
    end
    return CHAR_ALPHA + d_ext;
  endfunction

endpackage

[rtl/unsigned_to_radix_text.sv]
// Sequence: each digit of a value takes VALUE_BITS steps of the bit-serial
// restoring divider (one quotient bit a cycle), then a store read and an output load,
// which waits while out_stall holds the output; the terminator takes an empty fetch and a load.
// An out-of-range radix goes straight to the terminator; one transaction at a time.
// Throughput is set by the single shared divide step; in_stall is high until the terminator is loaded.
// Reset (rst, synchronous, active high) clears the sequencer, digit count and output valid.
// depends on utrt_pkg
module unsigned_to_radix_text #(
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  utrt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output utrt_pkg::out_item_t out_item
);
  import utrt_pkg::*;

  localparam int AW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CW = $clog2(VALUE_BITS + 1);

  state_t state, state_next;

  logic [VALUE_BITS-1:0] quo;
  logic [DIGIT_W-1:0]    rem;
  logic [RADIX_W-1:0]    radix_q;
  logic [AW-1:0]         bit_cnt;
  logic [CW-1:0]         digit_count;
  logic [DIGIT_W-1:0]    rd_data;
  logic [DIGIT_W-1:0]    digit_store [VALUE_BITS];

  logic [VALUE_BITS+VALUE_W-1:0] value_wide;
  logic [VALUE_BITS-1:0]         value_ext;
  logic                          radix_ok;
  logic [DIGIT_W:0]              trial;
  logic [DIGIT_W+1:0]            diff;
  logic                          take;
  logic [DIGIT_W-1:0]            rem_step;
  logic [VALUE_BITS-1:0]         quo_step;
  logic                          last_bit;
  logic                          out_free;
  logic [CW-1:0]                 count_dec;
  logic                          start, rd_en, load_digit, load_term;

  // input value fitted to the working width
  assign value_wide = {{VALUE_BITS{1'b0}}, in_item.value};
  assign value_ext  = value_wide[VALUE_BITS-1:0];
  assign radix_ok   = in_item.radix inside {[RADIX_MIN:RADIX_MAX]};

  // one restoring divide step: shift in the next dividend bit, subtract if it fits
  assign trial    = {rem, quo[VALUE_BITS-1]};
  assign diff     = {1'b0, trial} - {2'b00, radix_q};
  assign take     = !diff[DIGIT_W+1];
  assign rem_step = take ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
  assign quo_step = {quo[VALUE_BITS-2:0], take};
  assign last_bit = (bit_cnt == AW'(VALUE_BITS - 1));

  assign out_free  = !out_valid || !out_stall;
  assign count_dec = digit_count - CW'(1);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control strobes
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE) || rst;
    start      = 1'b0;
    rd_en      = 1'b0;
    load_digit = 1'b0;
    load_term  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid && !rst) begin
          start      = 1'b1;
          state_next = radix_ok ? ST_DIVIDE : ST_TERM;
        end
      end
      ST_DIVIDE: begin
        if (last_bit && (quo_step == '0)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (digit_count == '0) begin
          state_next = ST_TERM;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          load_digit = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_TERM: begin
        if (out_free) begin
          load_term  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // divider registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= value_ext;
      rem     <= '0;
      radix_q <= in_item.radix;
      bit_cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      quo <= quo_step;
      if (last_bit) begin
        rem     <= '0;
        bit_cnt <= '0;
      end else begin
        rem     <= rem_step;
        bit_cnt <= bit_cnt + AW'(1);
      end
    end
  end

  // digit count: up while dividing, down while reading back
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
    end else if (start) begin
      digit_count <= '0;
    end else if ((state == ST_DIVIDE) && last_bit) begin
      digit_count <= digit_count + CW'(1);
    end else if (rd_en) begin
      digit_count <= count_dec;
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if ((state == ST_DIVIDE) && last_bit) begin
      digit_store[digit_count[AW-1:0]] <= rem_step;
    end
  end

  // registered read for the reversal
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= digit_store[count_dec[AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_digit || load_term) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_digit) begin
      out_item.character <= digit_to_char(rd_data);
      out_item.last      <= 1'b0;
    end else if (load_term) begin
      out_item.character <= CHAR_NUL;
      out_item.last      <= 1'b1;
    end
  end

endmodule

[rtl/utrt_checker.sv]
// utrt_checker: port-level checks on the unsigned-to-radix-text converter,
// bound to the top level below
// depends on utrt_pkg and unsigned_to_radix_text
module utrt_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input utrt_pkg::out_item_t out_item
);
  import utrt_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output changed");

  // terminator carries the nul code
  a_term_nul: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.last |-> out_item.character == CHAR_NUL)
    else $error("terminator with nonzero character");

  // every digit is a decimal digit or an upper-case letter
  a_digit_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.last |->
      (out_item.character >= CHAR_ZERO && out_item.character <= CHAR_NINE) ||
      (out_item.character >= CHAR_UPPER_A && out_item.character <= CHAR_UPPER_Z))
    else $error("digit outside 0-9 and A-Z");

  // an accepted input keeps the block busy the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again without conversion");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind unsigned_to_radix_text utrt_checker u_utrt_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);
